// ----- rtl/core/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, constants and helpers for the CPU lifecycle table.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam int MAX_CPU_SLOTS = 64;
	localparam int IDX_W         = $clog2(MAX_CPU_SLOTS);
	localparam int CNT_W         = IDX_W + 1;
	localparam int GEN_W         = 32;
	localparam int ST_W          = 3;

	typedef enum logic [ST_W-1:0] {
		ST_OFFLINE  = 3'd0,
		ST_POSSIBLE = 3'd1,
		ST_STARTED  = 3'd2,
		ST_READY    = 3'd3,
		ST_ONLINE   = 3'd4,
		ST_FAILED   = 3'd5
	} lc_state_t;

	typedef struct packed {
		logic [IDX_W-1:0] cpu_index;
		logic [ST_W-1:0]  expected_state;
		logic [ST_W-1:0]  next_state;
	} clt_req_t;

	typedef struct packed {
		logic                     accepted;
		logic [ST_W-1:0]          current_state;
		logic [GEN_W-1:0]         current_generation;
		logic [MAX_CPU_SLOTS-1:0] started_mask;
		logic [MAX_CPU_SLOTS-1:0] online_mask;
	} clt_rsp_t;

	typedef struct packed {
		logic [ST_W-1:0]  state;
		logic [GEN_W-1:0] gen;
	} clt_entry_t;

	function automatic clt_entry_t reset_entry(input logic [IDX_W-1:0] idx);
		clt_entry_t e;
		if (idx == '0) begin
			e.state = ST_ONLINE;
			e.gen   = GEN_W'(2);
		end else begin
			e.state = ST_POSSIBLE;
			e.gen   = GEN_W'(1);
		end
		return e;
	endfunction

	function automatic logic legal_move(input logic [ST_W-1:0] from_st,
	                                    input logic [ST_W-1:0] to_st);
		logic ok;
		ok = ((from_st == ST_OFFLINE)  && (to_st == ST_POSSIBLE)) ||
		     ((from_st == ST_POSSIBLE) && (to_st == ST_STARTED))  ||
		     ((from_st == ST_STARTED)  && (to_st == ST_READY))    ||
		     ((from_st == ST_READY)    && (to_st == ST_ONLINE))   ||
		     (((from_st == ST_POSSIBLE) || (from_st == ST_STARTED) ||
		       (from_st == ST_READY)) && (to_st == ST_FAILED));
		return ok;
	endfunction

endpackage

// ----- rtl/core/clt_entry_store.sv -----
// ----------------------------------------------------------------------------
// clt_entry_store
// Per-CPU state/generation memory: registered read, one write port,
// valid bits standing in for reset values, write-to-read forwarding.
// ----------------------------------------------------------------------------
module clt_entry_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [clt_pkg::IDX_W-1:0] rd_idx,
	output clt_pkg::clt_entry_t       rd_entry,
	input  logic                      wr_en,
	input  logic [clt_pkg::IDX_W-1:0] wr_idx,
	input  clt_pkg::clt_entry_t       wr_entry
);

	clt_pkg::clt_entry_t               mem [clt_pkg::MAX_CPU_SLOTS];
	logic [clt_pkg::MAX_CPU_SLOTS-1:0] vld_q;
	clt_pkg::clt_entry_t               rd_data_q;
	clt_pkg::clt_entry_t               fwd_data_q;
	logic [clt_pkg::IDX_W-1:0]         rd_idx_q;
	logic                              rd_vld_q;
	logic                              fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q  <= mem[rd_idx];
			fwd_data_q <= wr_entry;
			rd_idx_q   <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= vld_q[rd_idx];
				fwd_hit_q <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	always_comb begin
		if (fwd_hit_q) begin
			rd_entry = fwd_data_q;
		end else if (rd_vld_q) begin
			rd_entry = rd_data_q;
		end else begin
			rd_entry = clt_pkg::reset_entry(rd_idx_q);
		end
	end

endmodule

// ----- rtl/core/clt_update.sv -----
// ----------------------------------------------------------------------------
// clt_update
// Checks one request against the stored entry and builds the new entry,
// the new masks and the response.
// ----------------------------------------------------------------------------
module clt_update (
	input  clt_pkg::clt_req_t                  req,
	input  clt_pkg::clt_entry_t                entry,
	input  logic [clt_pkg::CNT_W-1:0]          cpu_total,
	input  logic [clt_pkg::MAX_CPU_SLOTS-1:0]  started_cur,
	input  logic [clt_pkg::MAX_CPU_SLOTS-1:0]  online_cur,
	output logic                               apply,
	output clt_pkg::clt_entry_t                entry_new,
	output logic [clt_pkg::MAX_CPU_SLOTS-1:0]  started_new,
	output logic [clt_pkg::MAX_CPU_SLOTS-1:0]  online_new,
	output clt_pkg::clt_rsp_t                  rsp
);

	logic                              idx_ok;
	logic [clt_pkg::MAX_CPU_SLOTS-1:0] bit_sel;

	// a count above the slot total covers every index, so no clamp is needed
	assign idx_ok  = {1'b0, req.cpu_index} < cpu_total;
	assign bit_sel = clt_pkg::MAX_CPU_SLOTS'(1) << req.cpu_index;
	assign apply   = idx_ok && clt_pkg::legal_move(req.expected_state, req.next_state) &&
	                 (entry.state == req.expected_state);

	always_comb begin
		entry_new.state = req.next_state;
		entry_new.gen   = entry.gen + clt_pkg::GEN_W'(1);
		started_new     = started_cur;
		online_new      = online_cur;
		if (apply) begin
			if (req.next_state == clt_pkg::ST_STARTED) begin
				started_new = started_cur | bit_sel;
			end else if (req.next_state == clt_pkg::ST_ONLINE) begin
				online_new = online_cur | bit_sel;
			end else if (req.next_state == clt_pkg::ST_FAILED) begin
				started_new = started_cur & ~bit_sel;
				online_new  = online_cur & ~bit_sel;
			end
		end
	end

	always_comb begin
		rsp.accepted     = apply;
		rsp.started_mask = started_new;
		rsp.online_mask  = online_new;
		if (!idx_ok) begin
			rsp.current_state      = clt_pkg::ST_OFFLINE;
			rsp.current_generation = '0;
		end else if (apply) begin
			rsp.current_state      = entry_new.state;
			rsp.current_generation = entry_new.gen;
		end else begin
			rsp.current_state      = entry.state;
			rsp.current_generation = entry.gen;
		end
	end

endmodule

// ----- rtl/core/cpu_lifecycle_table_unit.sv -----
// ----------------------------------------------------------------------------
// cpu_lifecycle_table_unit
// Per-CPU lifecycle state and generation table with started/online masks.
// ----------------------------------------------------------------------------
// Takes one request transaction per cycle unless a stalled response blocks
// the input, and presents one response for each in the response register.
// The accepting edge reads the CPU's entry from a memory with a registered
// read; the first stage then checks and applies the move, and the edge that
// advances it writes the entry back and loads the response register. A
// stalled response holds the request in the first stage and stalls the input.
// A request to the CPU being written in the same cycle is served by forwarding,
// so back-to-back requests to one CPU see each other's updates. The table
// holds its reset contents immediately after reset. The user must write the
// CPU count only while no request is outstanding; the block does not enforce it.
// ----------------------------------------------------------------------------
module cpu_lifecycle_table_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  clt_pkg::clt_req_t         req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output clt_pkg::clt_rsp_t         rsp,
	input  logic                      cfg_we,
	input  logic [clt_pkg::CNT_W-1:0] cfg_data
);

	logic                              s1_valid_q;
	clt_pkg::clt_req_t                 req_s1;
	logic                              rsp_valid_q;
	clt_pkg::clt_rsp_t                 rsp_q;
	logic [clt_pkg::CNT_W-1:0]         cpu_total_q;
	logic [clt_pkg::MAX_CPU_SLOTS-1:0] started_q;
	logic [clt_pkg::MAX_CPU_SLOTS-1:0] online_q;

	logic                              advance;
	logic                              take;
	logic                              apply;
	clt_pkg::clt_entry_t               entry_rd;
	clt_pkg::clt_entry_t               entry_new;
	logic [clt_pkg::MAX_CPU_SLOTS-1:0] started_new;
	logic [clt_pkg::MAX_CPU_SLOTS-1:0] online_new;
	clt_pkg::clt_rsp_t                 rsp_new;

	assign advance   = s1_valid_q && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid_q || advance;
	assign take      = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	clt_entry_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (take),
		.rd_idx   (req.cpu_index),
		.rd_entry (entry_rd),
		.wr_en    (advance && apply),
		.wr_idx   (req_s1.cpu_index),
		.wr_entry (entry_new)
	);

	clt_update u_update (
		.req         (req_s1),
		.entry       (entry_rd),
		.cpu_total   (cpu_total_q),
		.started_cur (started_q),
		.online_cur  (online_q),
		.apply       (apply),
		.entry_new   (entry_new),
		.started_new (started_new),
		.online_new  (online_new),
		.rsp         (rsp_new)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			cpu_total_q <= clt_pkg::CNT_W'(1);
			started_q   <= clt_pkg::MAX_CPU_SLOTS'(1);
			online_q    <= clt_pkg::MAX_CPU_SLOTS'(1);
		end else begin
			if (take || advance) begin
				s1_valid_q <= take;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				started_q   <= started_new;
				online_q    <= online_new;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				cpu_total_q <= cfg_data;
			end
		end
	end

endmodule

// ----- rtl/core/clt_checker.sv -----
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks for cpu_lifecycle_table_unit, bound to the top level.
// ----------------------------------------------------------------------------
module clt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input clt_pkg::clt_rsp_t rsp
);

	// stalled response transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// with no response pending the pipeline can always take a request
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request blocked with empty response register");

	// an applied move never lands in offline or an unused code
	a_acc_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accepted |->
			rsp.current_state == clt_pkg::ST_POSSIBLE ||
			rsp.current_state == clt_pkg::ST_STARTED ||
			rsp.current_state == clt_pkg::ST_READY ||
			rsp.current_state == clt_pkg::ST_ONLINE ||
			rsp.current_state == clt_pkg::ST_FAILED)
		else $error("accepted move reports bad state");

	// reaching online must show up in the online mask
	a_acc_mask: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accepted && rsp.current_state == clt_pkg::ST_ONLINE |->
			rsp.online_mask != '0)
		else $error("online move without online mask bit");

endmodule

bind cpu_lifecycle_table_unit clt_checker u_clt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
